[design/control_frame_deframer_top_assert.svh]
// ----------------------------------------------------------------------------
// Control frame deframer: assertion macros
// Concurrent checks on the rising edge of clk, disabled while rst_n is low.
// The SYNTH build gets empty bodies.
// ----------------------------------------------------------------------------
`ifndef CONTROL_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define CONTROL_FRAME_DEFRAMER_TOP_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication
`define CFD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define CFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CFD_ASSERT_IMPL(label, ante, cons, msg)
`define CFD_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[design/cfd_pkg.sv]
// ----------------------------------------------------------------------------
// Control frame deframer package
// Shared types, status and role codes, phase codes and framing constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cfd_pkg;

    // Configuration port
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CATEGORY = 1'd1;

    localparam logic [CFG_DATA_W-1:0] HDR_SIZE_RESET = 31'd16;
    localparam logic [7:0]            CATEGORY_RESET = 8'h31;

    typedef logic [1:0] role_t;
    typedef logic [2:0] status_t;
    typedef logic [2:0] phase_t;

    // Byte roles
    localparam role_t ROLE_HDR   = 2'd0;
    localparam role_t ROLE_CMD   = 2'd1;
    localparam role_t ROLE_PARAM = 2'd2;
    localparam role_t ROLE_TRAIL = 2'd3;

    // Status codes
    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_MAGIC    = 3'd1;
    localparam status_t ST_HDR_SIZE = 3'd2;
    localparam status_t ST_DATA_SZ  = 3'd3;
    localparam status_t ST_VERSION  = 3'd4;
    localparam status_t ST_RESERVED = 3'd5;
    localparam status_t ST_START    = 3'd6;
    localparam status_t ST_CATEGORY = 3'd7;

    // Parser phases
    localparam phase_t PH_HUNT  = 3'd0;
    localparam phase_t PH_HSIZE = 3'd1;
    localparam phase_t PH_DSIZE = 3'd2;
    localparam phase_t PH_VER   = 3'd3;
    localparam phase_t PH_RSV   = 3'd4;
    localparam phase_t PH_PAY   = 3'd5;

    // Framing constants
    localparam logic [7:0] VERSION_BYTE  = 8'h01;
    localparam logic [7:0] RESERVED_BYTE = 8'h00;
    localparam logic [7:0] START_MARK    = 8'h21;
    localparam logic [7:0] END_MARK      = 8'h1A;

    typedef struct packed {
        logic [7:0] data_byte;
        role_t      role;
        logic       frame_end;
        status_t    status;
    } cfd_result_t;

    // Magic "ISCP" byte at a given position
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0:    m = 8'h49;
            2'd1:    m = 8'h53;
            2'd2:    m = 8'h43;
            default: m = 8'h50;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

[design/cfd_byte_if.sv]
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel carrying one stream byte per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[design/cfd_result_if.sv]
// ----------------------------------------------------------------------------
// Parse result channel
// Valid/ready channel carrying one tagged byte per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cfd_result_if;
    import cfd_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    role_t      role;
    logic       frame_end;
    status_t    status;

    modport source (output valid, output data_byte, output role, output frame_end,
                    output status, input ready);
    modport sink   (input valid, input data_byte, input role, input frame_end,
                    input status, output ready);
endinterface

`default_nettype wire

[design/control_frame_deframer_top.sv]
// ----------------------------------------------------------------------------
// Control frame deframer
// Parses framed control packets from a received byte stream.
//
// Channels: rx carries one stream byte per transaction (valid/ready); res
// returns one tagged result per byte: the byte echoed, its role (framing,
// command, parameter, trailing), frame_end and a status code. A failed
// header or framing check ends the frame with its status and the parser
// hunts for the magic again from the next byte.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 header
// size, 1 device category); write only while idle.
// Each result is registered before it appears on res. Throughput: one
// byte per cycle while the result register has room; the parser updates
// its framing state on every accepted byte.
// Reset: framing returns to the magic hunt, results are dropped, registers
// take header size 16 and category '1'.
// Stall: a two-entry result register keeps rx.ready high until both
// entries are full; then rx.ready drops until res takes a transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module control_frame_deframer_top #(
    parameter int MAX_DATA_SIZE = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    cfd_byte_if.sink                            rx,
    cfd_result_if.source                        res,
    input  wire logic                           cfg_we,
    input  wire logic [cfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cfd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import cfd_pkg::*;

    logic [CFG_DATA_W-1:0] hdr_size_reg;
    logic [7:0]            category_reg;

    logic        accept_ready;
    logic        res_valid;
    cfd_result_t res_data;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_size_reg <= HDR_SIZE_RESET;
            category_reg <= CATEGORY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HDR_SIZE: hdr_size_reg <= cfg_wdata;
                CFG_CATEGORY: category_reg <= cfg_wdata[7:0];
                default:      hdr_size_reg <= hdr_size_reg;
            endcase
        end
    end

    cfd_parser #(
        .MAX_DATA_SIZE (MAX_DATA_SIZE)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx           (rx),
        .accept_ready (accept_ready),
        .hdr_size     (hdr_size_reg),
        .category     (category_reg),
        .res_valid    (res_valid),
        .res_data     (res_data)
    );

    cfd_out_skid u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (res_valid),
        .in_data  (res_data),
        .in_ready (accept_ready),
        .res      (res)
    );

endmodule

`default_nettype wire

[design/cfd_parser.sv]
// ----------------------------------------------------------------------------
// Control frame deframer: byte parser
// Classifies each accepted byte against the packet layout and advances the
// framing state in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfd_parser #(
    parameter int MAX_DATA_SIZE = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    cfd_byte_if.sink                           rx,
    input  wire logic                          accept_ready,
    input  wire logic [cfd_pkg::CFG_DATA_W-1:0] hdr_size,
    input  wire logic [7:0]                    category,
    output      logic                          res_valid,
    output      cfd_pkg::cfd_result_t          res_data
);
    import cfd_pkg::*;

    localparam int POS_W = $clog2(MAX_DATA_SIZE + 1);

    phase_t           phase_reg,  phase_next;
    logic [POS_W-1:0] pos_reg,    pos_next;
    logic [31:0]      shift_reg,  shift_next;
    logic [POS_W-1:0] len_reg,    len_next;
    logic             ended_reg,  ended_next;

    logic        fire;
    logic [7:0]  b;
    logic [31:0] shv;
    logic        last;
    logic        bad;

    assign rx.ready = accept_ready;
    assign fire     = rx.valid & accept_ready;
    assign b        = rx.rx_byte;
    assign shv      = {shift_reg[23:0], b};
    assign last     = ({1'b0, pos_reg} + {{POS_W{1'b0}}, 1'b1}) >= {1'b0, len_reg};

    // Classify the byte and work out the next framing state
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        shift_next = shift_reg;
        len_next   = len_reg;
        ended_next = ended_reg;
        bad        = 1'b0;

        res_data.data_byte = b;
        res_data.role      = ROLE_HDR;
        res_data.frame_end = 1'b0;
        res_data.status    = ST_OK;

        case (phase_reg)
            PH_HUNT:
            begin
                if (b != magic_byte(pos_reg[1:0]))
                begin
                    bad             = 1'b1;
                    res_data.status = ST_MAGIC;
                end
                else if (pos_reg == POS_W'(3))
                begin
                    phase_next = PH_HSIZE;
                    pos_next   = '0;
                    shift_next = '0;
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            PH_HSIZE:
            begin
                if (pos_reg == POS_W'(3))
                begin
                    if (shv != {1'b0, hdr_size})
                    begin
                        bad             = 1'b1;
                        res_data.status = ST_HDR_SIZE;
                    end
                    else
                    begin
                        phase_next = PH_DSIZE;
                        pos_next   = '0;
                        shift_next = '0;
                    end
                end
                else
                begin
                    shift_next = shv;
                    pos_next   = pos_reg + POS_W'(1);
                end
            end
            PH_DSIZE:
            begin
                if (pos_reg == POS_W'(3))
                begin
                    if (shv[31] || (shv < 32'd2) || (shv > 32'(MAX_DATA_SIZE)))
                    begin
                        bad             = 1'b1;
                        res_data.status = ST_DATA_SZ;
                    end
                    else
                    begin
                        len_next   = shv[POS_W-1:0];
                        phase_next = PH_VER;
                        pos_next   = '0;
                        shift_next = '0;
                    end
                end
                else
                begin
                    shift_next = shv;
                    pos_next   = pos_reg + POS_W'(1);
                end
            end
            PH_VER:
            begin
                if (b != VERSION_BYTE)
                begin
                    bad             = 1'b1;
                    res_data.status = ST_VERSION;
                end
                else
                begin
                    phase_next = PH_RSV;
                    pos_next   = '0;
                end
            end
            PH_RSV:
            begin
                if (b != RESERVED_BYTE)
                begin
                    bad             = 1'b1;
                    res_data.status = ST_RESERVED;
                end
                else if (pos_reg == POS_W'(2))
                begin
                    phase_next = PH_PAY;
                    pos_next   = '0;
                    ended_next = 1'b0;
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            PH_PAY:
            begin
                if (pos_reg == POS_W'(0))
                begin
                    if (b != START_MARK)
                    begin
                        bad             = 1'b1;
                        res_data.status = ST_START;
                    end
                end
                else if (pos_reg == POS_W'(1))
                begin
                    if (b != category)
                    begin
                        bad             = 1'b1;
                        res_data.status = ST_CATEGORY;
                    end
                end
                else if (pos_reg < POS_W'(5))
                begin
                    res_data.role = ROLE_CMD;
                end
                else if (ended_reg)
                begin
                    res_data.role = ROLE_TRAIL;
                end
                else if (b == END_MARK)
                begin
                    ended_next    = 1'b1;
                    res_data.role = ROLE_TRAIL;
                end
                else
                begin
                    res_data.role = ROLE_PARAM;
                end

                // Close the frame on its last byte, otherwise advance
                if (last)
                begin
                    res_data.frame_end = 1'b1;
                    phase_next         = PH_HUNT;
                    pos_next           = '0;
                    shift_next         = '0;
                    ended_next         = 1'b0;
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
                pos_next   = '0;
                shift_next = '0;
                ended_next = 1'b0;
            end
        endcase

        // Any failed check ends the frame and restarts the hunt
        if (bad)
        begin
            res_data.frame_end = 1'b1;
            phase_next         = PH_HUNT;
            pos_next           = '0;
            shift_next         = '0;
            ended_next         = 1'b0;
        end
    end

    assign res_valid = fire;

    // Advance framing state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            pos_reg   <= '0;
            shift_reg <= '0;
            len_reg   <= '0;
            ended_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            shift_reg <= shift_next;
            len_reg   <= len_next;
            ended_reg <= ended_next;
        end
    end

endmodule

`default_nettype wire

[design/cfd_out_skid.sv]
// ----------------------------------------------------------------------------
// Control frame deframer: result register with skid stage
// Registers each result and absorbs one more while the receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "control_frame_deframer_top_assert.svh"

module cfd_out_skid (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire cfd_pkg::cfd_result_t in_data,
    output      logic                 in_ready,
    cfd_result_if.source              res
);
    import cfd_pkg::*;

    logic        main_valid_reg, main_valid_next;
    cfd_result_t main_data_reg,  main_data_next;
    logic        skid_valid_reg, skid_valid_next;
    cfd_result_t skid_data_reg;

    logic out_fire;

    assign in_ready = ~skid_valid_reg;
    assign out_fire = main_valid_reg & res.ready;

    // Decide where the incoming transaction lands
    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;

        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_valid && (!main_valid_reg || out_fire))
        begin
            main_valid_next = 1'b1;
            main_data_next  = in_data;
        end
        else if (in_valid)
        begin
            skid_valid_next = 1'b1;
        end
        else if (out_fire)
        begin
            main_valid_next = 1'b0;
        end
    end

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold payloads
    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        if (in_valid && in_ready && main_valid_reg && !out_fire)
        begin
            skid_data_reg <= in_data;
        end
    end

    assign res.valid     = main_valid_reg;
    assign res.data_byte = main_data_reg.data_byte;
    assign res.role      = main_data_reg.role;
    assign res.frame_end = main_data_reg.frame_end;
    assign res.status    = main_data_reg.status;

    `CFD_ASSERT_IMPL(a_skid_behind_main, skid_valid_reg, main_valid_reg, "skid full, main empty")
    `CFD_ASSERT_IMPL(a_status_ends_frame, res.valid && (res.status != ST_OK), res.frame_end, "error without frame end")
    `CFD_ASSERT_IMPL(a_tagged_byte_ok, res.valid && (res.role != ROLE_HDR), res.status == ST_OK, "tagged byte with error")
    `CFD_ASSERT_NEXT(a_skid_drains, skid_valid_reg && out_fire, !skid_valid_reg && main_valid_reg, "skid not drained")

endmodule

`default_nettype wire

[dv/tb_control_frame_deframer_top.sv]
// ----------------------------------------------------------------------------
// Control frame deframer testbench
// Sends a short table of hand-picked bytes after reset. It then sends random
// packet streams over several register settings. Most packets are well
// formed, and the rest carry a broken field, a truncated payload or line
// noise. A local parser model predicts each tagged result not pinned by hand, and the
// scoreboard compares each returned transaction with the oldest prediction.
// Both channels idle in random bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_control_frame_deframer_top;
    import cfd_pkg::*;

    localparam int MAX_DATA_SIZE   = 4096;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 165;
    localparam int CYCLE_LIMIT     = 500000;

    localparam logic [7:0] MAGIC_SEQ [4] = '{8'h49, 8'h53, 8'h43, 8'h50};

    // One row of the directed stream; pin marks a result typed in by hand
    typedef struct packed {
        logic [7:0] b;
        logic       pin;
        role_t      role;
        logic       fend;
        status_t    st;
    } stim_row_t;

    localparam stim_row_t DIRECTED [22] = '{
        '{8'h00, 1'b1, ROLE_HDR, 1'b1, ST_MAGIC},
        '{8'h49, 1'b1, ROLE_HDR, 1'b0, ST_OK},
        // a failing magic byte is not taken as a fresh start
        '{8'h49, 1'b1, ROLE_HDR, 1'b1, ST_MAGIC},
        '{8'hFF, 1'b1, ROLE_HDR, 1'b1, ST_MAGIC},
        // shortest legal packet, ends on the category byte
        '{8'h49, 1'b0, ROLE_HDR, 1'b0, ST_OK},
        '{8'h53, 1'b0, ROLE_HDR, 1'b0, ST_OK},
        '{8'h43, 1'b0, ROLE_HDR, 1'b0, ST_OK},
        '{8'h50, 1'b0, ROLE_HDR, 1'b0, ST_OK},
        '{8'h00, 1'b0, ROLE_HDR, 1'b0, ST_OK},
        '{8'h00, 1'b0, ROLE_HDR, 1'b0, ST_OK},
        '{8'h00, 1'b0, ROLE_HDR, 1'b0, ST_OK},
        '{8'h10, 1'b0, ROLE_HDR, 1'b0, ST_OK},
        '{8'h00, 1'b0, ROLE_HDR, 1'b0, ST_OK},
        '{8'h00, 1'b0, ROLE_HDR, 1'b0, ST_OK},
        '{8'h00, 1'b0, ROLE_HDR, 1'b0, ST_OK},
        '{8'h02, 1'b0, ROLE_HDR, 1'b0, ST_OK},
        '{8'h01, 1'b0, ROLE_HDR, 1'b0, ST_OK},
        '{8'h00, 1'b0, ROLE_HDR, 1'b0, ST_OK},
        '{8'h00, 1'b0, ROLE_HDR, 1'b0, ST_OK},
        '{8'h00, 1'b0, ROLE_HDR, 1'b0, ST_OK},
        '{8'h21, 1'b0, ROLE_HDR, 1'b0, ST_OK},
        '{8'h31, 1'b1, ROLE_HDR, 1'b1, ST_OK}
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    cfd_byte_if   rx_ch ();
    cfd_result_if res_ch ();

    control_frame_deframer_top #(
        .MAX_DATA_SIZE (MAX_DATA_SIZE)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Parser model state and register copies
    phase_t      prs_phase;
    logic [31:0] prs_pos;
    logic [31:0] prs_field;
    logic [31:0] prs_len;
    logic        prs_tail;
    logic [30:0] hdr_size;
    logic [7:0]  category;

    cfd_result_t pending_results [$];
    cfd_result_t typed_results [int];
    int          bytes_taken;
    int          errors;
    int          cycles;
    int          stall_left;
    bit          idle_on;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void restart_hunt();
        prs_phase = PH_HUNT;
        prs_pos   = '0;
        prs_field = '0;
        prs_tail  = 1'b0;
    endfunction

    // Advance the parser model by one byte and return its tagged result
    function automatic cfd_result_t parse_byte(input logic [7:0] b);
        cfd_result_t r;
        logic at_last;
        logic bad;
        r.data_byte = b;
        r.role      = ROLE_HDR;
        r.frame_end = 1'b0;
        r.status    = ST_OK;
        bad         = 1'b0;
        case (prs_phase)
            PH_HUNT:
            begin
                if (b == MAGIC_SEQ[prs_pos[1:0]])
                begin
                    prs_pos++;
                    if (prs_pos >= 4)
                    begin
                        prs_phase = PH_HSIZE;
                        prs_pos   = '0;
                        prs_field = '0;
                    end
                end
                else
                begin
                    r.frame_end = 1'b1;
                    r.status    = ST_MAGIC;
                    restart_hunt();
                end
            end
            PH_HSIZE, PH_DSIZE:
            begin
                prs_field = {prs_field[23:0], b};
                prs_pos++;
                if (prs_pos >= 4)
                begin
                    if (prs_phase == PH_HSIZE)
                    begin
                        if (prs_field != {1'b0, hdr_size})
                        begin
                            r.frame_end = 1'b1;
                            r.status    = ST_HDR_SIZE;
                            restart_hunt();
                        end
                        else
                        begin
                            prs_phase = PH_DSIZE;
                            prs_pos   = '0;
                            prs_field = '0;
                        end
                    end
                    else if (prs_field[31] || prs_field < 2 || prs_field > MAX_DATA_SIZE)
                    begin
                        r.frame_end = 1'b1;
                        r.status    = ST_DATA_SZ;
                        restart_hunt();
                    end
                    else
                    begin
                        prs_len   = prs_field;
                        prs_phase = PH_VER;
                        prs_pos   = '0;
                        prs_field = '0;
                    end
                end
            end
            PH_VER:
            begin
                if (b != VERSION_BYTE)
                begin
                    r.frame_end = 1'b1;
                    r.status    = ST_VERSION;
                    restart_hunt();
                end
                else
                begin
                    prs_phase = PH_RSV;
                    prs_pos   = '0;
                end
            end
            PH_RSV:
            begin
                if (b != RESERVED_BYTE)
                begin
                    r.frame_end = 1'b1;
                    r.status    = ST_RESERVED;
                    restart_hunt();
                end
                else
                begin
                    prs_pos++;
                    if (prs_pos >= 3)
                    begin
                        prs_phase = PH_PAY;
                        prs_pos   = '0;
                        prs_tail  = 1'b0;
                    end
                end
            end
            default:
            begin
                // payload: start mark, category, command chars, parameters, trailer
                at_last = (prs_pos + 32'd1 >= prs_len);
                if (prs_pos == 0)
                begin
                    if (b != START_MARK)
                    begin
                        bad      = 1'b1;
                        r.status = ST_START;
                    end
                end
                else if (prs_pos == 1)
                begin
                    if (b != category)
                    begin
                        bad      = 1'b1;
                        r.status = ST_CATEGORY;
                    end
                end
                else if (prs_pos < 5)
                    r.role = ROLE_CMD;
                else if (prs_tail)
                    r.role = ROLE_TRAIL;
                else if (b == END_MARK)
                begin
                    prs_tail = 1'b1;
                    r.role   = ROLE_TRAIL;
                end
                else
                    r.role = ROLE_PARAM;
                if (bad || at_last)
                begin
                    r.frame_end = 1'b1;
                    restart_hunt();
                end
                else
                    prs_pos++;
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endtask

    // Predict on every byte taken, compare every result returned
    always @(posedge clk)
    begin : scoreboard
        cfd_result_t want;
        cfd_result_t got;
        if (rst_n)
        begin
            if (rx_ch.valid && rx_ch.ready)
            begin
                want = parse_byte(rx_ch.rx_byte);
                if (typed_results.exists(bytes_taken))
                begin
                    want = typed_results[bytes_taken];
                    typed_results.delete(bytes_taken);
                end
                pending_results.push_back(want);
                bytes_taken++;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                got = {res_ch.data_byte, res_ch.role, res_ch.frame_end, res_ch.status};
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, got);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("data_byte", want.data_byte, got.data_byte);
                    check_field("role", 8'(want.role), 8'(got.role));
                    check_field("frame_end", 8'(want.frame_end), 8'(got.frame_end));
                    check_field("status", 8'(want.status), 8'(got.status));
                end
            end
        end
    end

    // Stall the result channel in random bursts
    always @(negedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 11) - 1;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= 1'b1;
    end

    // Abort a run that hangs
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offer one byte, with an optional gap first, and hold until it is taken
    task automatic push_byte(input logic [7:0] b, input logic pin, input cfd_result_t want);
        int target;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        if (pin)
            typed_results[bytes_taken] = want;
        target = bytes_taken + 1;
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(negedge clk);
        while (bytes_taken < target);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic wait_idle();
        rx_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
        repeat (2) @(negedge clk);
    endtask

    // Write both registers on consecutive cycles
    task automatic write_config(input logic [30:0] hs, input logic [7:0] cat);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HDR_SIZE;
        cfg_wdata <= hs;
        @(negedge clk);
        cfg_index <= CFG_CATEGORY;
        cfg_wdata <= {23'd0, cat};
        @(negedge clk);
        cfg_we <= 1'b0;
        hdr_size = hs;
        category = cat;
    endtask

    // Build one packet, mostly well formed, sometimes broken, and send it
    task automatic send_packet();
        logic [7:0]  pkt [$];
        logic [31:0] hsz_field;
        logic [31:0] len_field;
        logic [7:0]  v;
        int kind;
        int n_pay;
        int stop_at;
        int end_at;
        int bad_rsv;
        // 0..11 good, 12 hsize, 13 length, 14 version, 15 reserved,
        // 16 start mark, 17 category, 18 truncated, 19 longest length
        kind = $urandom_range(0, 19);

        // line noise ahead of the packet
        if ($urandom_range(0, 3) == 0)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                pkt.push_back(MAGIC_SEQ[0]);
                pkt.push_back(MAGIC_SEQ[1]);
                do
                    v = 8'($urandom);
                while (v == MAGIC_SEQ[2]);
                pkt.push_back(v);
            end
            else
                repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
        end

        hsz_field = {1'b0, hdr_size};
        if (kind == 12)
            hsz_field ^= 32'd1 << $urandom_range(0, 31);

        if (kind == 13)
        begin
            case ($urandom_range(0, 5))
                0:       len_field = 32'd0;
                1:       len_field = 32'd1;
                2:       len_field = MAX_DATA_SIZE + 1;
                3:       len_field = 32'h8000_0000;
                4:       len_field = 32'hFFFF_FFFF;
                default: len_field = $urandom_range(MAX_DATA_SIZE + 2, 32'h7FFF_FFFF);
            endcase
        end
        else if (kind == 19)
            len_field = MAX_DATA_SIZE;
        else
        begin
            case ($urandom_range(0, 7))
                0:       len_field = $urandom_range(2, 4);
                1:       len_field = $urandom_range(5, 6);
                2:       len_field = $urandom_range(60, 250);
                default: len_field = $urandom_range(7, 40);
            endcase
        end

        for (int i = 0; i < 4; i++)
            pkt.push_back(MAGIC_SEQ[i]);
        for (int i = 3; i >= 0; i--)
            pkt.push_back(hsz_field[8*i +: 8]);
        for (int i = 3; i >= 0; i--)
            pkt.push_back(len_field[8*i +: 8]);

        v = VERSION_BYTE;
        if (kind == 14)
        begin
            do
                v = 8'($urandom);
            while (v == VERSION_BYTE);
        end
        pkt.push_back(v);

        bad_rsv = (kind == 15) ? $urandom_range(0, 2) : -1;
        for (int i = 0; i < 3; i++)
        begin
            v = RESERVED_BYTE;
            if (i == bad_rsv)
                v = 8'($urandom_range(1, 255));
            pkt.push_back(v);
        end

        // payload only after a header that passes
        if (kind < 12 || kind > 15)
        begin
            n_pay = int'(len_field);
            stop_at = n_pay;
            if (kind == 16 || kind == 19)
                stop_at = 1;
            else if (kind == 17)
                stop_at = 2;
            else if (kind == 18)
                stop_at = $urandom_range(0, n_pay - 1);
            end_at = (n_pay <= 5 || $urandom_range(0, 3) == 0) ? -1 :
                     $urandom_range(5, n_pay - 1);
            for (int i = 0; i < stop_at; i++)
            begin
                if (i == 0)
                begin
                    v = START_MARK;
                    if (kind == 16 || kind == 19)
                    begin
                        do
                            v = 8'($urandom);
                        while (v == START_MARK);
                    end
                end
                else if (i == 1)
                begin
                    v = category;
                    if (kind == 17)
                    begin
                        do
                            v = 8'($urandom);
                        while (v == category);
                    end
                end
                else if (i < 5)
                    v = ($urandom_range(0, 7) == 0) ? END_MARK : 8'($urandom_range(8'h20, 8'h7E));
                else if (i == end_at)
                    v = END_MARK;
                else
                    v = 8'($urandom_range(0, 255));
                pkt.push_back(v);
            end
        end

        foreach (pkt[i])
            push_byte(pkt[i], 1'b0, '0);
    endtask

    // Main sequence
    initial
    begin
        int goal;
        bit phase_idle;
        logic [30:0] hs;
        logic [7:0] cat;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        res_ch.ready  = 1'b0;
        idle_on       = 1'b0;
        stall_left    = 0;
        bytes_taken   = 0;
        errors        = 0;
        cycles        = 0;
        hdr_size      = HDR_SIZE_RESET;
        category      = CATEGORY_RESET;
        prs_len       = '0;
        restart_hunt();

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // directed stream on the reset settings
        idle_on = 1'b1;
        foreach (DIRECTED[i])
            push_byte(DIRECTED[i].b, DIRECTED[i].pin,
                      {DIRECTED[i].b, DIRECTED[i].role, DIRECTED[i].fend, DIRECTED[i].st});

        // random phases; every phase after the first writes its register setting first
        goal = bytes_taken;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            case (p)
                1:       begin hs = 31'd0;          cat = 8'h00;          end
                2:       begin hs = 31'h7FFF_FFFF;  cat = 8'hFF;          end
                3:       begin hs = 31'($urandom);  cat = 8'($urandom);   end
                4:       begin hs = HDR_SIZE_RESET; cat = CATEGORY_RESET; end
                5:       begin hs = 31'($urandom_range(0, 255)); cat = END_MARK; end
                6:       begin hs = 31'($urandom);  cat = START_MARK;     end
                default: begin hs = HDR_SIZE_RESET; cat = CATEGORY_RESET; end
            endcase
            if (p > 0)
                write_config(hs, cat);
            phase_idle = (p != 4 && p != NUM_PHASES - 1);
            goal += ITEMS_PER_PHASE;
            while (bytes_taken < goal)
            begin
                idle_on = phase_idle && ($urandom_range(0, 3) != 0);
                send_packet();
            end
        end

        wait_idle();
        repeat (4) @(negedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[control_frame_deframer_top.f]
+incdir+design
design/cfd_pkg.sv
design/cfd_byte_if.sv
design/cfd_result_if.sv
design/cfd_parser.sv
design/cfd_out_skid.sv
design/control_frame_deframer_top.sv
dv/tb_control_frame_deframer_top.sv
